// ----- hw/rtl/bmhq_pkg.sv -----
// ============================================================================
// bmhq_pkg
// Shared constants, types and state codes for the binary max-heap queue.
// ============================================================================
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY      = 1024;
    localparam int KEY_WIDTH     = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = ADDR_W + 2;
    localparam int ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

    localparam int S_TDATA_W = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;
    localparam int M_BITS    = KEY_WIDTH + PAYLOAD_WIDTH + CNT_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [PAYLOAD_WIDTH-1:0] payload;
        logic [KEY_WIDTH-1:0]     key;
    } entry_t;

    typedef struct packed {
        logic   op;
        entry_t entry;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         entry_count;
        logic                     has_top;
        logic [PAYLOAD_WIDTH-1:0] top_payload;
        logic [KEY_WIDTH-1:0]     top_key;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_LOAD,
        ST_DN_RDL,
        ST_DN_CMPL,
        ST_DN_CMPR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmhq_ram.sv -----
// ============================================================================
// bmhq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmhq_ctrl.sv -----
// ============================================================================
// bmhq_ctrl
// Sift sequencer: walks the heap one level at a time through the RAM port
// with a single shared key comparator.
// ============================================================================
`default_nettype none

module bmhq_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire bmhq_pkg::req_t               req,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output bmhq_pkg::result_t                 res,
    output logic                              ram_we,
    output logic [bmhq_pkg::ADDR_W-1:0]       ram_waddr,
    output bmhq_pkg::entry_t                  ram_wdata,
    output logic [bmhq_pkg::ADDR_W-1:0]       ram_raddr,
    input  wire bmhq_pkg::entry_t             ram_rdata
);

    bmhq_pkg::state_t                state_reg, state_next;
    logic [bmhq_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [bmhq_pkg::ADDR_W-1:0]     pos_reg, pos_next;
    bmhq_pkg::entry_t                cur_reg, cur_next;
    bmhq_pkg::entry_t                best_reg, best_next;
    logic [bmhq_pkg::ADDR_W-1:0]     best_idx_reg, best_idx_next;
    logic                            best_child_reg, best_child_next;
    logic [1:0]                      status_reg, status_next;
    bmhq_pkg::entry_t                root_reg;

    logic [bmhq_pkg::KEY_WIDTH-1:0]  cmp_a;
    logic [bmhq_pkg::KEY_WIDTH-1:0]  cmp_b;
    logic                            cmp_gt;
    logic [bmhq_pkg::ADDR_W-1:0]     parent;
    logic [bmhq_pkg::CHILD_W-1:0]    child_l;
    logic [bmhq_pkg::CHILD_W-1:0]    child_r;
    logic [bmhq_pkg::CHILD_W-1:0]    count_ext;

    // shared comparator
    assign cmp_gt = cmp_a > cmp_b;

    assign parent    = (pos_reg - bmhq_pkg::ADDR_W'(1)) >> 1;
    assign child_l   = {1'b0, pos_reg, 1'b1};
    assign child_r   = child_l + bmhq_pkg::CHILD_W'(1);
    assign count_ext = bmhq_pkg::CHILD_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmhq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        status_reg     <= status_next;
        if (ram_we && ram_waddr == '0) begin
            root_reg <= ram_wdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = '0;
        cmp_a           = cur_reg.key;
        cmp_b           = ram_rdata.key;
        req_ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            bmhq_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    status_next = bmhq_pkg::STAT_OK;
                    if (req.op == bmhq_pkg::OP_PUSH) begin
                        if (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                            status_next = bmhq_pkg::STAT_FULL;
                            state_next  = bmhq_pkg::ST_DONE;
                        end else begin
                            cur_next   = req.entry;
                            pos_next   = count_reg[bmhq_pkg::ADDR_W-1:0];
                            count_next = count_reg + bmhq_pkg::CNT_W'(1);
                            state_next = bmhq_pkg::ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = bmhq_pkg::STAT_EMPTY;
                            state_next  = bmhq_pkg::ST_DONE;
                        end else begin
                            count_next = count_reg - bmhq_pkg::CNT_W'(1);
                            state_next = bmhq_pkg::ST_DN_LAST;
                        end
                    end
                end
            end
            bmhq_pkg::ST_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    ram_raddr  = parent;
                    state_next = bmhq_pkg::ST_UP_CMP;
                end
            end
            bmhq_pkg::ST_UP_CMP: begin
                cmp_a  = cur_reg.key;
                cmp_b  = ram_rdata.key;
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = bmhq_pkg::ST_UP_RD;
                end else begin
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_DN_LAST: begin
                pos_next = '0;
                if (count_reg == '0) begin
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    ram_raddr  = count_reg[bmhq_pkg::ADDR_W-1:0];
                    state_next = bmhq_pkg::ST_DN_LOAD;
                end
            end
            bmhq_pkg::ST_DN_LOAD: begin
                cur_next   = ram_rdata;
                state_next = bmhq_pkg::ST_DN_RDL;
            end
            bmhq_pkg::ST_DN_RDL: begin
                if (child_l >= count_ext) begin
                    ram_we     = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    ram_raddr  = child_l[bmhq_pkg::ADDR_W-1:0];
                    state_next = bmhq_pkg::ST_DN_CMPL;
                end
            end
            bmhq_pkg::ST_DN_CMPL: begin
                cmp_a         = ram_rdata.key;
                cmp_b         = cur_reg.key;
                best_idx_next = child_l[bmhq_pkg::ADDR_W-1:0];
                if (cmp_gt) begin
                    best_next       = ram_rdata;
                    best_child_next = 1'b1;
                end else begin
                    best_next       = cur_reg;
                    best_child_next = 1'b0;
                end
                if (child_r < count_ext) begin
                    ram_raddr  = child_r[bmhq_pkg::ADDR_W-1:0];
                    state_next = bmhq_pkg::ST_DN_CMPR;
                end else if (cmp_gt) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    pos_next   = child_l[bmhq_pkg::ADDR_W-1:0];
                    state_next = bmhq_pkg::ST_DN_RDL;
                end else begin
                    ram_we     = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_DN_CMPR: begin
                cmp_a  = ram_rdata.key;
                cmp_b  = best_reg.key;
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = child_r[bmhq_pkg::ADDR_W-1:0];
                    state_next = bmhq_pkg::ST_DN_RDL;
                end else if (best_child_reg) begin
                    ram_wdata  = best_reg;
                    pos_next   = best_idx_reg;
                    state_next = bmhq_pkg::ST_DN_RDL;
                end else begin
                    state_next = bmhq_pkg::ST_DONE;
                end
            end
            bmhq_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status      = status_reg;
        res.entry_count = count_reg;
        res.has_top     = (count_reg != '0);
        res.top_key     = res.has_top ? root_reg.key : '0;
        res.top_payload = res.has_top ? root_reg.payload : '0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/binary_max_heap_queue.sv -----
// Push: sifts the new entry up from the next free slot, reading the parent at each level climbed.
// Pop: sifts the last entry down from the root, reading each child in turn (one RAM read port).
// Pop on empty or push on full returns a status only; a pop that leaves the heap empty skips the sift.
// One request at a time, taken in the idle cycle after the result is registered; a new request
// is not accepted until the previous result has been handed to the output register.
// Reset (aresetn low, synchronous) empties the heap; RAM contents are not cleared.
// ============================================================================
// binary_max_heap_queue
// Binary max-heap priority queue of key/payload entries on a stream interface.
// ============================================================================
`default_nettype none

module binary_max_heap_queue (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // entry_key, entry_payload
    input  wire logic [bmhq_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // top_key, top_payload, entry_count, zero pad
    output logic      [bmhq_pkg::M_TDATA_W-1:0]   m_tdata,
    // has_top, status
    output logic      [bmhq_pkg::M_TUSER_W-1:0]   m_tuser
);

    bmhq_pkg::req_t    req;
    bmhq_pkg::result_t res;
    bmhq_pkg::result_t out_reg;
    logic              m_valid_reg, m_valid_next;
    logic              res_valid;
    logic              res_ready;

    logic                          ram_we;
    logic [bmhq_pkg::ADDR_W-1:0]   ram_waddr;
    bmhq_pkg::entry_t              ram_wdata;
    logic [bmhq_pkg::ADDR_W-1:0]   ram_raddr;
    bmhq_pkg::entry_t              ram_rdata;

    assign req.op            = s_tuser;
    assign req.entry.key     = s_tdata[bmhq_pkg::KEY_WIDTH-1:0];
    assign req.entry.payload = s_tdata[bmhq_pkg::KEY_WIDTH +: bmhq_pkg::PAYLOAD_WIDTH];

    bmhq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_W),
        .DEPTH (bmhq_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bmhq_pkg::M_TDATA_W'({out_reg.entry_count, out_reg.top_payload,
                                            out_reg.top_key});
    assign m_tuser  = {out_reg.status, out_reg.has_top};

endmodule

`default_nettype wire

// ----- hw/rtl/bmhq_checker.sv -----
// ============================================================================
// bmhq_checker
// Port-level checks on the heap queue result stream.
// ============================================================================
`default_nettype none

module bmhq_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bmhq_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [bmhq_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int CNT_LSB = bmhq_pkg::KEY_WIDTH + bmhq_pkg::PAYLOAD_WIDTH;

    logic [bmhq_pkg::CNT_W-1:0] cnt;
    logic [CNT_LSB-1:0]         top_bits;
    logic                       has_top;
    logic [1:0]                 status;

    assign cnt      = m_tdata[CNT_LSB +: bmhq_pkg::CNT_W];
    assign top_bits = m_tdata[CNT_LSB-1:0];
    assign has_top  = m_tuser[0];
    assign status   = m_tuser[2:1];

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_has_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (has_top == (cnt != '0)))
        else $error("has_top disagrees with entry count");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !has_top |-> (top_bits == '0))
        else $error("top entry not zero on empty heap");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == bmhq_pkg::STAT_FULL)
            |-> (cnt == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)))
        else $error("full status with heap not full");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/binary_max_heap_queue_tb.sv -----
// ============================================================================
// binary_max_heap_queue_tb
// Self-checking bench for the max-heap queue. A request driver and a result
// monitor run off the clock; every accepted request is applied to a local
// heap model and the predicted top/count/status is compared field by field
// against each accepted result. Covers empty pops, equal keys and a complete
// drain, with random idle on both sides, a long result-side stall and sender
// pauses until all results are back.
// ============================================================================

module binary_max_heap_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic {IT_REQ, IT_SYNC} item_kind_t;

    typedef struct {
        item_kind_t                         kind;
        logic                               op;
        logic [bmhq_pkg::KEY_WIDTH-1:0]     key;
        logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] pay;
    } heap_req_t;

    typedef struct {
        logic [bmhq_pkg::KEY_WIDTH-1:0]     top_key;
        logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] top_pay;
        logic                               has_top;
        logic [bmhq_pkg::CNT_W-1:0]         count;
        logic [1:0]                         status;
    } heap_report_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bmhq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bmhq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [bmhq_pkg::M_TUSER_W-1:0] m_tuser;

    heap_req_t    req_backlog[$];
    heap_report_t reports_due[$];

    logic [bmhq_pkg::KEY_WIDTH-1:0]     heap_keys[bmhq_pkg::CAPACITY];
    logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] heap_pays[bmhq_pkg::CAPACITY];
    int                                 heap_fill = 0;
    int                                 plan_fill = 0;

    int errors      = 0;
    int reqs_taken  = 0;
    int rslts_taken = 0;

    binary_max_heap_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void swap_slots(int a, int b);
        logic [bmhq_pkg::KEY_WIDTH-1:0]     tk;
        logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] tp;
        tk = heap_keys[a];
        tp = heap_pays[a];
        heap_keys[a] = heap_keys[b];
        heap_pays[a] = heap_pays[b];
        heap_keys[b] = tk;
        heap_pays[b] = tp;
    endfunction

    function automatic heap_report_t heap_apply(logic op,
                                                logic [bmhq_pkg::KEY_WIDTH-1:0] key,
                                                logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] pay);
        heap_report_t r;
        int           pos;
        int           up;
        int           best;
        int           lft;
        int           rgt;
        bit           done;
        r.status = bmhq_pkg::STAT_OK;
        if (op == bmhq_pkg::OP_PUSH) begin
            if (heap_fill >= bmhq_pkg::CAPACITY) begin
                r.status = bmhq_pkg::STAT_FULL;
            end else begin
                pos = heap_fill;
                heap_keys[pos] = key;
                heap_pays[pos] = pay;
                heap_fill++;
                done = 0;
                while (pos > 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] < heap_keys[pos]) begin
                        swap_slots(up, pos);
                        pos = up;
                    end else begin
                        done = 1;
                    end
                end
            end
        end else if (heap_fill == 0) begin
            r.status = bmhq_pkg::STAT_EMPTY;
        end else begin
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            heap_pays[0] = heap_pays[heap_fill];
            pos = 0;
            done = 0;
            while (!done) begin
                best = pos;
                lft  = 2 * pos + 1;
                rgt  = lft + 1;
                if (lft < heap_fill && heap_keys[lft] > heap_keys[pos]) best = lft;
                if (rgt < heap_fill && heap_keys[rgt] > heap_keys[best]) best = rgt;
                if (best == pos) begin
                    done = 1;
                end else begin
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.has_top = (heap_fill > 0);
        r.top_key = r.has_top ? heap_keys[0] : '0;
        r.top_pay = r.has_top ? heap_pays[0] : '0;
        r.count   = heap_fill[bmhq_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic void check_field(string what, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    task automatic queue_req(logic op, logic [bmhq_pkg::KEY_WIDTH-1:0] key,
                             logic [bmhq_pkg::PAYLOAD_WIDTH-1:0] pay);
        heap_req_t it;
        it.kind = IT_REQ;
        it.op   = op;
        it.key  = key;
        it.pay  = pay;
        req_backlog = {req_backlog, it};
        if (op == bmhq_pkg::OP_PUSH && plan_fill < bmhq_pkg::CAPACITY) plan_fill++;
        if (op == bmhq_pkg::OP_POP && plan_fill > 0) plan_fill--;
    endtask

    task automatic queue_sync();
        heap_req_t it;
        it.kind = IT_SYNC;
        it.op   = bmhq_pkg::OP_PUSH;
        it.key  = '0;
        it.pay  = '0;
        req_backlog = {req_backlog, it};
    endtask

    // request driver
    always @(negedge aclk) begin : drive_proc
        heap_req_t it;
        logic      nxt_valid;
        int        reqs_seen;
        int        send_gap;
        int        send_run;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            reqs_seen = 0;
            send_gap  = 0;
            send_run  = 0;
        end else begin
            nxt_valid = s_tvalid;
            if (reqs_taken != reqs_seen) begin
                reqs_seen = reqs_taken;
                nxt_valid = 1'b0;
                send_gap  = draw_gap(send_run);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_backlog.size() > 0) begin
                    it = req_backlog[0];
                    if (it.kind == IT_SYNC) begin
                        if (reports_due.size() == 0) void'(req_backlog.pop_front());
                    end else begin
                        void'(req_backlog.pop_front());
                        s_tuser   <= it.op;
                        s_tdata   <= bmhq_pkg::S_TDATA_W'({it.pay, it.key});
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // result-side ready, with one long stall once traffic is flowing
    always @(negedge aclk) begin : sink_proc
        int  rslts_seen;
        int  rdy_wait;
        int  rdy_run;
        int  hold_left;
        bit  hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rslts_seen = 0;
            rdy_wait   = 0;
            rdy_run    = 0;
            hold_left  = 0;
            hold_done  = 0;
        end else begin
            if (rslts_taken != rslts_seen) begin
                rslts_seen = rslts_taken;
                rdy_wait   = draw_gap(rdy_run);
            end
            if (!hold_done && reqs_taken >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rdy_wait > 0) begin
                rdy_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // handshake monitor: check results, then predict newly accepted requests
    always @(posedge aclk) begin : watch_proc
        heap_report_t want;
        heap_report_t fresh;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rslts_taken++;
                if (reports_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = reports_due.pop_front();
                    check_field("top_key", want.top_key, m_tdata[bmhq_pkg::KEY_WIDTH-1:0]);
                    check_field("top_payload", want.top_pay,
                                m_tdata[bmhq_pkg::KEY_WIDTH +: bmhq_pkg::PAYLOAD_WIDTH]);
                    check_field("entry_count", want.count,
                                m_tdata[bmhq_pkg::KEY_WIDTH + bmhq_pkg::PAYLOAD_WIDTH
                                        +: bmhq_pkg::CNT_W]);
                    check_field("has_top", want.has_top, m_tuser[0]);
                    check_field("status", want.status, m_tuser[2:1]);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = heap_apply(s_tuser, s_tdata[bmhq_pkg::KEY_WIDTH-1:0],
                                   s_tdata[bmhq_pkg::KEY_WIDTH +: bmhq_pkg::PAYLOAD_WIDTH]);
                reports_due = {reports_due, fresh};
                reqs_taken++;
            end
        end
    end

    initial begin
        int                             seg;
        int                             n;
        int                             push_pct;
        int                             key_mode;
        logic                           op;
        logic [bmhq_pkg::KEY_WIDTH-1:0] key;

        // directed: empty pop, key/payload extremes, ties, alternating bits
        queue_req(bmhq_pkg::OP_POP, 16'h0000, 32'h0);
        queue_req(bmhq_pkg::OP_PUSH, 16'h0000, 32'h0000_0000);
        queue_req(bmhq_pkg::OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(bmhq_pkg::OP_PUSH, 16'h1234, 32'h1111_1111);
        queue_req(bmhq_pkg::OP_PUSH, 16'h1234, 32'h2222_2222);
        queue_req(bmhq_pkg::OP_PUSH, 16'h8000, 32'h8000_0001);
        repeat (6) queue_req(bmhq_pkg::OP_POP, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(bmhq_pkg::OP_PUSH, 16'hAAAA, 32'h5555_5555);
        queue_req(bmhq_pkg::OP_PUSH, 16'h5555, 32'hAAAA_AAAA);
        queue_req(bmhq_pkg::OP_PUSH, 16'h0000, 32'hDEAD_0001);
        queue_req(bmhq_pkg::OP_PUSH, 16'h0000, 32'hDEAD_0002);
        repeat (5) queue_req(bmhq_pkg::OP_POP, 16'h0000, 32'h0);
        queue_sync();

        // random mix: per-segment push bias and key spread
        for (seg = 0; seg < 9; seg++) begin
            push_pct = $urandom_range(25, 80);
            key_mode = $urandom_range(0, 2);
            for (n = 0; n < 50; n++) begin
                op = ($urandom_range(0, 99) < push_pct) ? bmhq_pkg::OP_PUSH
                                                        : bmhq_pkg::OP_POP;
                case (key_mode)
                    0: key = bmhq_pkg::KEY_WIDTH'($urandom);
                    1: key = bmhq_pkg::KEY_WIDTH'($urandom_range(0, 7));
                    default: key = ($urandom_range(0, 1) != 0)
                                   ? bmhq_pkg::KEY_WIDTH'($urandom)
                                   : bmhq_pkg::KEY_WIDTH'(16'hFFFF - $urandom_range(0, 3));
                endcase
                queue_req(op, key, $urandom);
            end
            if ($urandom_range(0, 2) == 0) queue_sync();
        end

        // drain past empty
        queue_sync();
        while (plan_fill > 0)
            queue_req(bmhq_pkg::OP_POP, bmhq_pkg::KEY_WIDTH'($urandom), $urandom);
        queue_req(bmhq_pkg::OP_POP, bmhq_pkg::KEY_WIDTH'($urandom), $urandom);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_tvalid || reports_due.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (errors == 0) begin
            $display("binary_max_heap_queue_tb passed");
        end else begin
            $display("binary_max_heap_queue_tb failed");
        end
        $finish;
    end

    initial begin
        #18_000_000;
        $display("binary_max_heap_queue_tb failed");
        $finish;
    end

endmodule
